// File: hw/rtl/cfsf_pkg.sv
// ----------------------------------------------------------------------------
// CAN frame serial framer package
// Shared types and character constants for the frame-to-byte-stream framer.
// ----------------------------------------------------------------------------
package cfsf_pkg;

    localparam int unsigned DATA_SLOTS = 8;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // One classified frame as it waits between the front and the back.
    typedef struct packed {
        logic [7:0]                  header;
        logic [7:0]                  id_lo;
        logic [3:0]                  n;
        logic [DATA_SLOTS-1:0][7:0]  data;
    } t_desc;

    typedef enum logic [2:0] {
        ST_DOLLAR,
        ST_F,
        ST_HDR,
        ST_ID,
        ST_DATA,
        ST_SUM,
        ST_CR,
        ST_LF
    } t_seq_state;

endpackage

// File: hw/rtl/cfsf_if.sv
// ----------------------------------------------------------------------------
// CAN frame serial framer channels
// Valid/ready channels for incoming frames and outgoing record bytes.
// ----------------------------------------------------------------------------
interface cfsf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] id_high_byte;
    logic [7:0] id_low_byte;
    logic [7:0] length_code_byte;
    logic [7:0] data_0;
    logic [7:0] data_1;
    logic [7:0] data_2;
    logic [7:0] data_3;
    logic [7:0] data_4;
    logic [7:0] data_5;
    logic [7:0] data_6;
    logic [7:0] data_7;

    modport source (
        output valid, id_high_byte, id_low_byte, length_code_byte,
        output data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
        input  ready
    );
    modport sink (
        input  valid, id_high_byte, id_low_byte, length_code_byte,
        input  data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7,
        output ready
    );
endinterface

interface cfsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// File: hw/rtl/can_frame_to_serial_framer.sv
// ----------------------------------------------------------------------------
// CAN frame to serial record framer
// Turns each received standard frame into a text-framed serial byte record.
// ----------------------------------------------------------------------------
// Each frame accepted on i_frame produces the record '$', 'F', header
// (length nibble over identifier bits 10..8), identifier low byte, up to
// MAX_DATA_BYTES data bytes, an 8-bit checksum of header, identifier and
// data, then CR and LF, with last_byte set on the LF. The record leaves on
// o_byte at one byte per cycle while o_byte.ready is high; a frame with n
// data bytes gives a record of 7 + n bytes (7 to 15), sequenced by the
// back end. A two-entry frame queue in front of the sequencer holds the
// frame whose record is being sent, so one further frame can be accepted
// while that record is still being sent or stalled. The first byte of a
// record is offered in the cycle after its frame enters an empty queue.
module can_frame_to_serial_framer #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfsf_frame_if.sink    i_frame,
    cfsf_byte_if.source   o_byte
);
    import cfsf_pkg::*;

    t_desc  w_head;
    logic   w_head_valid;
    logic   w_pop;

    cfsf_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame      (i_frame),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_head_valid (w_head_valid)
    );

    cfsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_byte       (o_byte)
    );

endmodule

// File: hw/rtl/cfsf_front.sv
// ----------------------------------------------------------------------------
// CAN frame serial framer front end
// Accepts frames, forms header, identifier low byte and clamped data count,
// and holds them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module cfsf_front #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfsf_frame_if.sink         i_frame,
    input  logic               i_pop,
    output cfsf_pkg::t_desc    o_head,
    output logic               o_head_valid
);
    import cfsf_pkg::*;

    localparam logic [3:0] MAX_N = 4'(MAX_DATA_BYTES);

    t_desc       r_slot [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    t_desc       w_desc;
    logic [3:0]  w_len;
    logic        w_push;

    assign i_frame.ready = (r_count != 2'd2);
    assign w_push        = i_frame.valid && i_frame.ready;
    assign w_len         = i_frame.length_code_byte[3:0];

    always_comb begin
        w_desc.header = {w_len, 1'b0, i_frame.id_high_byte[7:5]};
        w_desc.id_lo  = {i_frame.id_high_byte[4:0], i_frame.id_low_byte[7:5]};
        w_desc.n      = (w_len > MAX_N) ? MAX_N : w_len;
        w_desc.data   = {i_frame.data_7, i_frame.data_6, i_frame.data_5, i_frame.data_4,
                         i_frame.data_3, i_frame.data_2, i_frame.data_1, i_frame.data_0};
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, w_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_desc;
        end
    end

    assign o_head       = r_slot[r_rd_ptr];
    assign o_head_valid = (r_count != 2'd0);

endmodule

// File: hw/rtl/cfsf_back.sv
// ----------------------------------------------------------------------------
// CAN frame serial framer back end
// Walks one queued frame through the record bytes and keeps the running
// checksum, one byte per transaction.
// ----------------------------------------------------------------------------
module cfsf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfsf_pkg::t_desc    i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    cfsf_byte_if.source        o_byte
);
    import cfsf_pkg::*;

    t_seq_state  r_state, n_state;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_sum, n_sum;
    logic        w_fire;
    logic [7:0]  w_data;
    logic        w_data_last;

    assign o_byte.valid = i_head_valid;
    assign w_fire       = i_head_valid && o_byte.ready;
    assign w_data       = i_head.data[r_idx];
    assign w_data_last  = ({1'b0, r_idx} + 4'd1) == i_head.n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DOLLAR;
            r_idx   <= 3'd0;
            r_sum   <= 8'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        n_sum            = r_sum;
        o_pop            = 1'b0;
        o_byte.out_byte  = CH_DOLLAR;
        o_byte.last_byte = 1'b0;
        unique case (r_state)
            ST_DOLLAR: begin
                o_byte.out_byte = CH_DOLLAR;
                if (w_fire) n_state = ST_F;
            end
            ST_F: begin
                o_byte.out_byte = CH_F;
                if (w_fire) n_state = ST_HDR;
            end
            ST_HDR: begin
                o_byte.out_byte = i_head.header;
                if (w_fire) begin
                    n_sum   = i_head.header;
                    n_state = ST_ID;
                end
            end
            ST_ID: begin
                o_byte.out_byte = i_head.id_lo;
                if (w_fire) begin
                    n_sum   = r_sum + i_head.id_lo;
                    n_idx   = 3'd0;
                    n_state = (i_head.n == 4'd0) ? ST_SUM : ST_DATA;
                end
            end
            ST_DATA: begin
                o_byte.out_byte = w_data;
                if (w_fire) begin
                    n_sum = r_sum + w_data;
                    n_idx = r_idx + 3'd1;
                    if (w_data_last) n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_byte.out_byte = r_sum;
                if (w_fire) n_state = ST_CR;
            end
            ST_CR: begin
                o_byte.out_byte = CH_CR;
                if (w_fire) n_state = ST_LF;
            end
            ST_LF: begin
                o_byte.out_byte  = CH_LF;
                o_byte.last_byte = 1'b1;
                if (w_fire) begin
                    o_pop   = 1'b1;
                    n_state = ST_DOLLAR;
                end
            end
            default: begin
                n_state = ST_DOLLAR;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // Once a record has started, its frame must stay at the head of the queue.
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DOLLAR) |-> i_head_valid)
        else $error("record in progress without a queued frame");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA) |-> ({1'b0, r_idx} < i_head.n))
        else $error("data index beyond frame data count");

    a_sum_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_state == ST_HDR) |=> (r_sum == $past(i_head.header)))
        else $error("checksum not seeded from header");

    a_record_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_state == ST_LF) |=> (r_state == ST_DOLLAR && r_idx == 3'd0 ||
                                          r_state == ST_DOLLAR))
        else $error("sequencer did not return to record start");
`endif

endmodule
